FILE: design/buzzer_note_envelope_player_assert.svh
// Assertion macros used by the checker file.
`ifndef BUZZER_NOTE_ENVELOPE_PLAYER_ASSERT_SVH
`define BUZZER_NOTE_ENVELOPE_PLAYER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BNEP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BNEP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/bnep_pkg.sv
package bnep_pkg;

    localparam int UNIT_MS_DEF    = 5;
    localparam int HOLD_UNITS_DEF = 15;

    localparam logic [7:0] HOLD_MS_RST   = 8'd75;
    localparam logic [7:0] START_AMP_RST = 8'd255;

    localparam logic [5:0] REST_PITCH = 6'd36;

    // operation codes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_NOTE = 2'd1;
    localparam logic [1:0] OP_STOP = 2'd2;

    // configuration register indexes
    localparam logic CFG_HOLD_MS   = 1'b0;
    localparam logic CFG_START_AMP = 1'b1;

    typedef struct packed {
        logic [7:0]  amplitude;
        logic [14:0] half_period;
        logic        tone_enabled;
        logic        note_busy;
        logic        rejected;
    } t_result;

    localparam logic [15:0] PERIOD_ROM [37] = '{
        16'd42272, 16'd39898, 16'd37660, 16'd35546, 16'd33550, 16'd31668,
        16'd29890, 16'd28212, 16'd26630, 16'd25134, 16'd23724, 16'd22392,
        16'd21136, 16'd19950, 16'd18828, 16'd17772, 16'd16776, 16'd15834,
        16'd14944, 16'd14106, 16'd13314, 16'd12568, 16'd11862, 16'd11196,
        16'd10568, 16'd9974,  16'd9414,  16'd8886,  16'd8388,  16'd7920,
        16'd7472,  16'd7054,  16'd6658,  16'd6284,  16'd5930,  16'd5598,
        16'd0
    };

    // pitch is already clipped to the rest index
    function automatic logic [14:0] half_period(input logic [5:0] pitch);
        logic [15:0] per;
        per = PERIOD_ROM[pitch];
        return per[15:1];
    endfunction

endpackage

FILE: design/bnep_core.sv
module bnep_core #(
    parameter int UNIT_MS    = 5,
    parameter int HOLD_UNITS = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_accept,
    input  logic [1:0]        i_operation,
    input  logic [5:0]        i_note_pitch,
    input  logic [7:0]        i_note_length,
    output bnep_pkg::t_result o_result
);
    import bnep_pkg::*;

    localparam int  MS_W    = $clog2(UNIT_MS);
    localparam bit  HAS_MS2 = (UNIT_MS > 2);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_HOLD  = 2'd1;
    localparam logic [1:0] PH_DECAY = 2'd2;
    localparam logic [1:0] PH_TAIL  = 2'd3;

    logic [7:0]      r_hold_ms, r_start_amp;
    logic [1:0]      r_phase, n_phase;
    logic [7:0]      r_hold_left, n_hold_left;
    logic [MS_W-1:0] r_ms, n_ms;
    logic [7:0]      r_units, n_units;
    logic [7:0]      r_level, n_level;
    logic [5:0]      r_pitch, n_pitch;
    logic            r_tone, n_tone;

    logic [5:0] pitch_c;
    logic [7:0] len_after_hold;
    logic [7:0] units_dec;
    logic [7:0] hold_dec;
    logic [1:0] div104, div88;
    logic [7:0] lvl_sub;
    logic       rej;

    function automatic logic [7:0] sub_sat(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : 8'd0;
    endfunction

    always_comb begin
        pitch_c        = (i_note_pitch > REST_PITCH) ? REST_PITCH : i_note_pitch;
        len_after_hold = (i_note_length >= 8'(HOLD_UNITS)) ?
                         (i_note_length - 8'(HOLD_UNITS)) : 8'd0;
        units_dec      = (r_units != 8'd0) ? (r_units - 8'd1) : 8'd0;
        hold_dec       = (r_hold_left != 8'd0) ? (r_hold_left - 8'd1) : 8'd0;
        div104 = (r_level >= 8'd208) ? 2'd2 : ((r_level >= 8'd104) ? 2'd1 : 2'd0);
        div88  = (r_level >= 8'd176) ? 2'd2 : ((r_level >= 8'd88) ? 2'd1 : 2'd0);
        lvl_sub = r_level;
        if (r_level != 8'd0) begin
            if (r_ms == '0) begin
                lvl_sub = sub_sat(r_level, {6'd0, div104} + 8'd1);
            end else if (HAS_MS2 && r_ms == MS_W'(2)) begin
                lvl_sub = sub_sat(r_level, {6'd0, div88});
            end
        end

        n_phase     = r_phase;
        n_hold_left = r_hold_left;
        n_ms        = r_ms;
        n_units     = r_units;
        n_level     = r_level;
        n_pitch     = r_pitch;
        n_tone      = r_tone;
        rej         = 1'b0;

        case (i_operation)
            OP_TICK: begin
                if (r_phase == PH_IDLE) begin
                    n_tone  = 1'b0;
                    n_level = 8'd0;
                end else if (r_phase == PH_HOLD) begin
                    n_hold_left = hold_dec;
                    if (hold_dec == 8'd0) begin
                        n_ms    = '0;
                        n_phase = (r_units != 8'd0) ? PH_DECAY : PH_IDLE;
                    end
                end else begin
                    n_level = lvl_sub;
                    if (r_ms == MS_W'(UNIT_MS - 1)) begin
                        n_ms    = '0;
                        n_units = units_dec;
                        if (units_dec == 8'd0) begin
                            if (r_phase == PH_TAIL) begin
                                n_tone  = 1'b0;
                                n_level = 8'd0;
                            end
                            n_phase = PH_IDLE;
                        end
                    end else begin
                        n_ms = r_ms + MS_W'(1);
                    end
                end
            end
            OP_NOTE: begin
                if (r_phase != PH_IDLE) begin
                    rej = 1'b1;
                end else if (pitch_c == REST_PITCH && r_tone && r_pitch != REST_PITCH) begin
                    // rest right after a sounding note: keep decaying the tone
                    n_units     = i_note_length;
                    n_ms        = '0;
                    n_hold_left = 8'd0;
                    if (i_note_length == 8'd0) begin
                        n_tone  = 1'b0;
                        n_level = 8'd0;
                    end else begin
                        n_phase = PH_TAIL;
                    end
                end else begin
                    if (pitch_c != REST_PITCH) begin
                        n_tone  = 1'b1;
                        n_level = r_start_amp;
                    end else begin
                        n_tone  = 1'b0;
                        n_level = 8'd0;
                    end
                    n_pitch     = pitch_c;
                    n_units     = len_after_hold;
                    n_ms        = '0;
                    n_hold_left = r_hold_ms;
                    if (r_hold_ms != 8'd0) begin
                        n_phase = PH_HOLD;
                    end else begin
                        n_phase = (len_after_hold != 8'd0) ? PH_DECAY : PH_IDLE;
                    end
                end
            end
            OP_STOP: begin
                n_phase     = PH_IDLE;
                n_hold_left = 8'd0;
                n_ms        = '0;
                n_units     = 8'd0;
                n_pitch     = REST_PITCH;
                n_tone      = 1'b0;
                n_level     = 8'd0;
            end
            default: begin
            end
        endcase

        o_result.amplitude    = n_level;
        o_result.half_period  = half_period(n_pitch);
        o_result.tone_enabled = n_tone;
        o_result.note_busy    = (n_phase != PH_IDLE);
        o_result.rejected     = rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ms   <= HOLD_MS_RST;
            r_start_amp <= START_AMP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HOLD_MS:   r_hold_ms   <= i_cfg_data;
                CFG_START_AMP: r_start_amp <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_hold_left <= 8'd0;
            r_ms        <= '0;
            r_units     <= 8'd0;
            r_level     <= 8'd0;
            r_pitch     <= REST_PITCH;
            r_tone      <= 1'b0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_hold_left <= n_hold_left;
            r_ms        <= n_ms;
            r_units     <= n_units;
            r_level     <= n_level;
            r_pitch     <= n_pitch;
            r_tone      <= n_tone;
        end
    end

endmodule

FILE: design/bnep_out.sv
module bnep_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bnep_pkg::t_result i_data,
    input  logic              i_stall,
    output logic              o_valid,
    output bnep_pkg::t_result o_data,
    output logic              o_full
);
    import bnep_pkg::*;

    logic    r_main_v, r_skid_v;
    t_result r_main, r_skid;
    logic    pop;

    assign pop     = r_main_v && !i_stall;
    assign o_valid = r_main_v;
    assign o_data  = r_main;
    assign o_full  = r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            // drain the skid beat into the output slot
            if (pop) begin
                r_skid_v <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_v || pop) begin
                r_main_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (pop) begin
            r_main_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (!r_main_v || pop) begin
                r_main <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

endmodule

FILE: design/buzzer_note_envelope_player.sv
// Buzzer note envelope player.
// Input channel (i_in_valid / o_in_stall) carries one beat per command:
// a 1 ms tick, a note start (pitch and length in 5 ms units) or a stop.
// Every accepted beat returns exactly one result beat on the output
// channel (o_out_valid / i_out_stall): amplitude, tone half period,
// tone enable, busy flag and a reject flag for notes sent while busy.
// Throughput: one beat per cycle while o_in_stall is low; the envelope
// state updates in a single pass of logic between the state registers
// and the result register (or the skid register while the slot is held).
// When the receiver stalls, the result slot holds its beat and one more
// beat lands in a skid register; o_in_stall then rises until the slot
// drains, so no beat is lost.
// Configuration (i_cfg_valid / o_cfg_ready, always ready): index 0 sets
// hold_ms, index 1 sets start_amplitude. Write only while idle.
// Reset (synchronous, active low): hold_ms = 75, start_amplitude = 255,
// player idle, tone off, amplitude 0, pitch on rest, output empty.
module buzzer_note_envelope_player #(
    parameter int UNIT_MS    = bnep_pkg::UNIT_MS_DEF,
    parameter int HOLD_UNITS = bnep_pkg::HOLD_UNITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [5:0]  i_note_pitch,
    input  logic [7:0]  i_note_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_amplitude,
    output logic [14:0] o_half_period,
    output logic        o_tone_enabled,
    output logic        o_note_busy,
    output logic        o_rejected
);
    import bnep_pkg::*;

    logic    accept;
    t_result result, out_data;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && !o_in_stall;

    bnep_core #(
        .UNIT_MS    (UNIT_MS),
        .HOLD_UNITS (HOLD_UNITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_operation   (i_operation),
        .i_note_pitch  (i_note_pitch),
        .i_note_length (i_note_length),
        .o_result      (result)
    );

    bnep_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (result),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (out_data),
        .o_full  (o_in_stall)
    );

    assign o_amplitude    = out_data.amplitude;
    assign o_half_period  = out_data.half_period;
    assign o_tone_enabled = out_data.tone_enabled;
    assign o_note_busy    = out_data.note_busy;
    assign o_rejected     = out_data.rejected;

endmodule

FILE: design/bnep_checker.sv
`include "buzzer_note_envelope_player_assert.svh"

module bnep_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_amplitude,
    input logic [14:0] o_half_period,
    input logic        o_tone_enabled,
    input logic        o_note_busy,
    input logic        o_rejected
);

    // a stalled result beat stays put
    `BNEP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_amplitude) && $stable(o_half_period) && $stable(o_rejected), "stalled result beat changed")

    // a note is only rejected while another one is playing
    `BNEP_ASSERT_NOW(a_rej_busy, i_clk, i_rst_n, o_out_valid && o_rejected, o_note_busy, "note rejected while idle")

    // silence always clears the level
    `BNEP_ASSERT_NOW(a_quiet_zero, i_clk, i_rst_n, o_out_valid && !o_tone_enabled, o_amplitude == 8'd0, "amplitude nonzero with tone off")

    // a running tone never sits on the rest pitch
    `BNEP_ASSERT_NOW(a_tone_pitch, i_clk, i_rst_n, o_out_valid && o_tone_enabled, o_half_period != 15'd0, "tone on with rest period")

    // input stall only rises with a held result beat
    `BNEP_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, o_in_stall, o_out_valid, "input stalled with empty output")

endmodule

bind buzzer_note_envelope_player bnep_checker u_bnep_checker (.*);
